@@ rtl/core/bvm_pkg.sv @@
package bvm_pkg;

  localparam int unsigned AddrWidth = 12;
  localparam int unsigned MemDepth = 4096;
  localparam int unsigned FontBase = 12'h050;
  localparam int unsigned FontBytes = 80;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef logic [7:0] byte_t;
  typedef logic [AddrWidth-1:0] addr_t;

  typedef struct packed {
    logic [1:0] kind;
    addr_t address;
    byte_t load_byte;
    logic [15:0] keys_down;
    byte_t random_byte;
  } in_item_t;

  typedef struct packed {
    addr_t next_pc;
    logic [15:0] executed_opcode;
    logic sound_on;
    logic waiting_key;
    logic screen_changed;
    logic stack_fault;
    logic [63:0] row_pixels;
  } out_item_t;

  // Font glyph byte, one call per place that needs it.
  function automatic byte_t font_byte(input logic [6:0] idx);
    byte_t r;
    r = 8'h00;
    case (idx)
      7'd0: r = 8'hF0; 7'd1: r = 8'h90; 7'd2: r = 8'h90; 7'd3: r = 8'h90; 7'd4: r = 8'hF0;
      7'd5: r = 8'h20; 7'd6: r = 8'h60; 7'd7: r = 8'h20; 7'd8: r = 8'h20; 7'd9: r = 8'h70;
      7'd10: r = 8'hF0; 7'd11: r = 8'h10; 7'd12: r = 8'hF0; 7'd13: r = 8'h80;
      7'd14: r = 8'hF0; 7'd15: r = 8'hF0; 7'd16: r = 8'h10; 7'd17: r = 8'hF0;
      7'd18: r = 8'h10; 7'd19: r = 8'hF0; 7'd20: r = 8'h90; 7'd21: r = 8'h90;
      7'd22: r = 8'hF0; 7'd23: r = 8'h10; 7'd24: r = 8'h10; 7'd25: r = 8'hF0;
      7'd26: r = 8'h80; 7'd27: r = 8'hF0; 7'd28: r = 8'h10; 7'd29: r = 8'hF0;
      7'd30: r = 8'hF0; 7'd31: r = 8'h80; 7'd32: r = 8'hF0; 7'd33: r = 8'h90;
      7'd34: r = 8'hF0; 7'd35: r = 8'hF0; 7'd36: r = 8'h10; 7'd37: r = 8'h20;
      7'd38: r = 8'h40; 7'd39: r = 8'h40; 7'd40: r = 8'hF0; 7'd41: r = 8'h90;
      7'd42: r = 8'hF0; 7'd43: r = 8'h90; 7'd44: r = 8'hF0; 7'd45: r = 8'hF0;
      7'd46: r = 8'h90; 7'd47: r = 8'hF0; 7'd48: r = 8'h10; 7'd49: r = 8'hF0;
      7'd50: r = 8'hF0; 7'd51: r = 8'h90; 7'd52: r = 8'hF0; 7'd53: r = 8'h90;
      7'd54: r = 8'h90; 7'd55: r = 8'hE0; 7'd56: r = 8'h90; 7'd57: r = 8'hE0;
      7'd58: r = 8'h90; 7'd59: r = 8'hE0; 7'd60: r = 8'hF0; 7'd61: r = 8'h80;
      7'd62: r = 8'h80; 7'd63: r = 8'h80; 7'd64: r = 8'hF0; 7'd65: r = 8'hE0;
      7'd66: r = 8'h90; 7'd67: r = 8'h90; 7'd68: r = 8'h90; 7'd69: r = 8'hE0;
      7'd70: r = 8'hF0; 7'd71: r = 8'h80; 7'd72: r = 8'hF0; 7'd73: r = 8'h80;
      7'd74: r = 8'hF0; 7'd75: r = 8'hF0; 7'd76: r = 8'h80; 7'd77: r = 8'hF0;
      7'd78: r = 8'h80; 7'd79: r = 8'h80;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/bvm_main_mem.sv @@
module bvm_main_mem (
  input  logic             clk,
  input  logic             we,
  input  bvm_pkg::addr_t   waddr,
  input  bvm_pkg::byte_t   wdata,
  input  bvm_pkg::addr_t   raddr,
  output bvm_pkg::byte_t   rdata
);
  import bvm_pkg::*;

  byte_t mem [MemDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bvm_frame_mem.sv @@
module bvm_frame_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [63:0] wdata,
  input  logic [4:0]  raddr,
  output logic [63:0] rdata
);
  logic [63:0] mem [32];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bytecode_vm_interpreter_core.sv @@
// Channel | Dir | tdata fields (low bit first)                              | tuser
// s_axis  | in  | address[11:0] load_byte[19:12] keys_down[35:20] random[43:36] | kind[1:0]
// m_axis  | out | next_pc[11:0] opcode[27:12] sound waiting changed fault[31:28]
//         |     |   row_pixels[95:32]                                         | none
// After reset the block sweeps both memories, writing zeros and the font, before it
// accepts a beat. An instruction fetches its two bytes, then executes; a draw steps
// each sprite row through its reads and write-back, and block loads and stores, BCD
// stores and clear screen go one register, digit or row at a time, all set by the
// single memory ports. A finished result waits in the output register while the next
// beat is taken; that item holds in its last state until the register is free.
module bytecode_vm_interpreter_core #(
  parameter int unsigned PROGRAM_START = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // address, load_byte, keys_down, random_byte
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // next_pc, executed_opcode, sound_on, waiting_key,
                                     // screen_changed, stack_fault, row_pixels
);
  import bvm_pkg::*;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_LDRD  = 5'd2;
  localparam logic [4:0] S_FRD   = 5'd3;
  localparam logic [4:0] S_F0    = 5'd5;
  localparam logic [4:0] S_F1    = 5'd6;
  localparam logic [4:0] S_F2    = 5'd7;
  localparam logic [4:0] S_EXEC  = 5'd8;
  localparam logic [4:0] S_CLS   = 5'd9;
  localparam logic [4:0] S_DRA   = 5'd10;
  localparam logic [4:0] S_DRB   = 5'd11;
  localparam logic [4:0] S_DRC   = 5'd12;
  localparam logic [4:0] S_BCD   = 5'd13;
  localparam logic [4:0] S_ST    = 5'd14;
  localparam logic [4:0] S_LDA   = 5'd15;
  localparam logic [4:0] S_LDB   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;
  localparam logic [4:0] S_BCD2  = 5'd19;

  logic [4:0]  state;
  logic [11:0] sweep;
  in_item_t    item;
  addr_t       pc, ir;
  byte_t       v [16];
  addr_t       stk [16];
  logic [3:0]  sp;
  byte_t       dt, st;
  logic [15:0] op;
  logic        waiting, changed, fault;
  logic [63:0] rowv;
  logic [4:0]  cnt;
  logic        hit;
  byte_t       spr;
  logic [7:0]  bcd_rem;
  out_item_t   res;

  logic  mwe;
  addr_t mwaddr, mraddr;
  byte_t mwdata, mrdata;
  logic        fwe;
  logic [4:0]  fwaddr, fraddr;
  logic [63:0] fwdata, frdata;

  bvm_main_mem u_mem (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata), .raddr(mraddr), .rdata(mrdata)
  );
  bvm_frame_mem u_fb (
    .clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata), .raddr(fraddr), .rdata(frdata)
  );

  logic [3:0]  x, y, n;
  byte_t       kk, a, b;
  logic [5:0]  dx;
  logic [4:0]  dy;
  logic [5:0]  drow;
  logic [3:0]  key_low;
  logic [63:0] spr_row;
  logic [8:0]  sum9;
  byte_t       bcd_tens, bcd_units;

  assign x  = op[11:8];
  assign y  = op[7:4];
  assign n  = op[3:0];
  assign kk = op[7:0];
  assign a  = v[x];
  assign b  = v[y];
  assign dx = v[x][5:0];
  assign dy = v[y][4:0];
  assign drow = {1'b0, dy} + {1'b0, cnt};
  assign sum9 = {1'b0, a} + {1'b0, b};
  assign spr_row = {spr, 56'd0} >> dx;

  always_comb begin
    key_low = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (item.keys_down[k]) key_low = 4'(k);
    end
  end

  // Tens and units of the remainder below one hundred.
  always_comb begin
    bcd_tens = 8'd0;
    for (int t = 1; t < 10; t++) begin
      if (bcd_rem >= 8'(10 * t)) bcd_tens = 8'(t);
    end
  end
  assign bcd_units = bcd_rem - {bcd_tens[4:0], 3'b000} - {bcd_tens[6:0], 1'b0};

  // Memory port steering.
  always_comb begin
    mwe = 1'b0;
    mwaddr = item.address;
    mwdata = 8'h00;
    mraddr = pc;
    fwe = 1'b0;
    fwaddr = drow[4:0];
    fwdata = frdata ^ spr_row;
    fraddr = drow[4:0];
    unique case (state)
      S_INIT: begin
        mwe = 1'b1;
        mwaddr = sweep;
        mwdata = (sweep >= addr_t'(FontBase) &&
                  sweep < addr_t'(FontBase + FontBytes)) ?
                 font_byte(7'(sweep - addr_t'(FontBase))) : 8'h00;
        fwe = 1'b1;
        fwaddr = sweep[4:0];
        fwdata = 64'd0;
      end
      S_IDLE: begin
        fraddr = s_axis_tdata[4:0];
      end
      S_LDRD: begin
        mwe = item.kind == KIND_LOAD;
        mwdata = item.load_byte;
      end
      S_F0: mraddr = pc;
      S_F1: mraddr = pc + 12'd1;
      S_CLS: begin
        fwe = 1'b1;
        fwaddr = cnt;
        fwdata = 64'd0;
      end
      S_DRA: mraddr = ir + addr_t'(cnt);
      S_DRC: fwe = 1'b1;
      S_BCD, S_BCD2: begin
        mwe = 1'b1;
        mwaddr = ir + addr_t'(cnt);
        mwdata = (cnt == 5'd0) ? {6'd0, bcd_rem >= 8'd200 ? 2'd2 :
                                        bcd_rem >= 8'd100 ? 2'd1 : 2'd0} :
                 (cnt == 5'd1) ? bcd_tens : bcd_units;
      end
      S_ST: begin
        mwe = 1'b1;
        mwaddr = ir + addr_t'(cnt);
        mwdata = v[cnt[3:0]];
      end
      S_LDA: mraddr = ir + addr_t'(cnt);
      default: ;
    endcase
  end

  assign s_axis_tready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= 12'd0;
      pc <= addr_t'(PROGRAM_START);
      ir <= '0;
      sp <= '0;
      dt <= '0;
      st <= '0;
      for (int i = 0; i < 16; i++) v[i] <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_INIT: begin
          sweep <= sweep + 12'd1;
          if (sweep == 12'(MemDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            item <= {s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[19:12],
                     s_axis_tdata[35:20], s_axis_tdata[43:36]};
            op <= '0;
            waiting <= 1'b0;
            changed <= 1'b0;
            fault <= 1'b0;
            rowv <= '0;
            if (s_axis_tuser == KIND_EXEC) state <= S_F0;
            else if (s_axis_tuser == KIND_READ) state <= S_FRD;
            else state <= S_LDRD;
          end
        end
        S_LDRD: state <= S_OUT;
        S_FRD: begin
          if (item.address < 12'd32) rowv <= frdata;
          state <= S_OUT;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          op[15:8] <= mrdata;
          state <= S_F2;
        end
        S_F2: begin
          op[7:0] <= mrdata;
          pc <= pc + 12'd2;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_FIN;
          cnt <= '0;
          unique case (op[15:12])
            4'h0: begin
              if (op == 16'h00E0) begin
                changed <= 1'b1;
                state <= S_CLS;
              end else if (op == 16'h00EE) begin
                fault <= sp == 4'd0;
                sp <= sp - 4'd1;
                pc <= stk[sp - 4'd1];
              end
            end
            4'h1: pc <= op[11:0];
            4'h2: begin
              stk[sp] <= pc;
              fault <= sp == 4'd15;
              sp <= sp + 4'd1;
              pc <= op[11:0];
            end
            4'h3: if (a == kk) pc <= pc + 12'd2;
            4'h4: if (a != kk) pc <= pc + 12'd2;
            4'h5: if (a == b) pc <= pc + 12'd2;
            4'h6: v[x] <= kk;
            4'h7: v[x] <= a + kk;
            4'h8: begin
              case (n)
                4'h0: v[x] <= b;
                4'h1: v[x] <= a | b;
                4'h2: v[x] <= a & b;
                4'h3: v[x] <= a ^ b;
                4'h4: begin
                  v[x] <= sum9[7:0];
                  v[15] <= {7'd0, sum9[8]};
                end
                4'h5: begin
                  v[x] <= a - b;
                  v[15] <= {7'd0, a >= b};
                end
                4'h6: begin
                  v[x] <= a >> 1;
                  v[15] <= {7'd0, a[0]};
                end
                4'h7: begin
                  v[x] <= b - a;
                  v[15] <= {7'd0, b >= a};
                end
                4'hE: begin
                  v[x] <= a << 1;
                  v[15] <= {7'd0, a[7]};
                end
                default: ;
              endcase
            end
            4'h9: if (a != b) pc <= pc + 12'd2;
            4'hA: ir <= op[11:0];
            4'hB: pc <= op[11:0] + {4'd0, v[0]};
            4'hC: v[x] <= item.random_byte & kk;
            4'hD: begin
              changed <= 1'b1;
              hit <= 1'b0;
              state <= S_DRA;
            end
            4'hE: begin
              if (kk == 8'h9E && item.keys_down[a[3:0]]) pc <= pc + 12'd2;
              if (kk == 8'hA1 && !item.keys_down[a[3:0]]) pc <= pc + 12'd2;
            end
            default: begin
              case (kk)
                8'h07: v[x] <= dt;
                8'h0A: begin
                  if (item.keys_down == 16'd0) begin
                    pc <= pc - 12'd2;
                    waiting <= 1'b1;
                  end else begin
                    v[x] <= {4'd0, key_low};
                  end
                end
                8'h15: dt <= a;
                8'h18: st <= a;
                8'h1E: ir <= ir + {4'd0, a};
                8'h29: ir <= addr_t'(FontBase) + {4'd0, a[3:0], 2'b00} + {8'd0, a[3:0]};
                8'h33: begin
                  bcd_rem <= a;
                  state <= S_BCD;
                end
                8'h55: state <= S_ST;
                8'h65: state <= S_LDA;
                default: ;
              endcase
            end
          endcase
        end
        S_CLS: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_FIN;
        end
        // Draw: address the sprite byte, then the frame row, then write back.
        S_DRA: begin
          if ({1'b0, cnt} >= {1'b0, n} || drow[5]) begin
            v[15] <= {7'd0, hit};
            state <= S_FIN;
          end else begin
            state <= S_DRB;
          end
        end
        S_DRB: begin
          spr <= mrdata;
          state <= S_DRC;
        end
        S_DRC: begin
          if ((frdata & spr_row) != 64'd0) hit <= 1'b1;
          cnt <= cnt + 5'd1;
          state <= S_DRA;
        end
        S_BCD: begin
          // Hundreds written; keep the tens and units for the next writes.
          bcd_rem <= bcd_rem >= 8'd200 ? bcd_rem - 8'd200 :
                     bcd_rem >= 8'd100 ? bcd_rem - 8'd100 : bcd_rem;
          cnt <= 5'd1;
          state <= S_BCD2;
        end
        S_BCD2: begin
          if (cnt == 5'd2) state <= S_FIN;
          else cnt <= cnt + 5'd1;
        end
        S_ST: begin
          cnt <= cnt + 5'd1;
          if (cnt[3:0] == x) state <= S_FIN;
        end
        S_LDA: state <= S_LDB;
        S_LDB: begin
          v[cnt[3:0]] <= mrdata;
          cnt <= cnt + 5'd1;
          state <= (cnt[3:0] == x) ? S_FIN : S_LDA;
        end
        S_FIN: begin
          if (dt != 8'd0) dt <= dt - 8'd1;
          if (st != 8'd0) st <= st - 8'd1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            res.next_pc <= pc;
            res.executed_opcode <= op;
            res.sound_on <= st != 8'd0;
            res.waiting_key <= waiting;
            res.screen_changed <= changed;
            res.stack_fault <= fault;
            res.row_pixels <= rowv;
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {res.row_pixels, res.stack_fault, res.screen_changed,
                         res.waiting_key, res.sound_on, res.executed_opcode, res.next_pc};

endmodule
